>>> rtl/core/uss_pkg.sv
`timescale 1ns / 1ps

package uss_pkg;

   localparam int unsigned MAX_LEN_DEFAULT = 4095;

   localparam int unsigned PREFIX_LEN = 4;
   localparam int unsigned NID_MIN    = 2;
   localparam int unsigned NID_MAX    = 32;
   // bytes before the specific string: prefix, colon after the id
   localparam int unsigned NSS_BASE   = 5;

   localparam logic [7:0] CHAR_COLON    = 8'h3a;
   localparam logic [7:0] CHAR_HYPHEN   = 8'h2d;
   localparam logic [7:0] CHAR_QUESTION = 8'h3f;
   localparam logic [7:0] CHAR_PLUS     = 8'h2b;
   localparam logic [7:0] CHAR_EQUAL    = 8'h3d;
   localparam logic [7:0] CHAR_HASH     = 8'h23;
   localparam logic [7:0] CHAR_NUL      = 8'h00;

   typedef enum logic [2:0] {
      PHASE_PREFIX = 3'b001,
      PHASE_NID    = 3'b010,
      PHASE_NSS    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [5:0]  nid_len;
      logic [11:0] nss_len;
      logic        has_r;
      logic [11:0] r_start;
      logic [11:0] r_len;
      logic        has_q;
      logic [11:0] q_start;
      logic [11:0] q_len;
      logic        has_f;
      logic [11:0] f_start;
      logic [11:0] f_len;
   } rsp_type;

   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h75;
         2'd1:    ch = 8'h72;
         2'd2:    ch = 8'h6e;
         default: ch = CHAR_COLON;
      endcase
      return ch;
   endfunction

   function automatic logic id_char_ok(input logic [7:0] ch);
      return (ch inside {[8'h30:8'h39], [8'h61:8'h7a], [8'h41:8'h5a]}) ||
             (ch == CHAR_HYPHEN);
   endfunction

endpackage

>>> rtl/core/urn_syntax_splitter_core.sv
`timescale 1ns / 1ps

// channel   ports                        carries
// request   req_valid req_ready req_data  one byte of the name, last marker
// response  rsp_valid rsp_ready rsp_data  validity and part offsets per name
//
// one request per cycle, but for a last byte that waits as below; the response for
// a name is registered and appears in the cycle after its last byte is taken.
// reset clears the scan state and drops any pending response.
// non-last bytes are taken even while a response waits; a last byte waits
// only until the response register is free.
module urn_syntax_splitter_core #(
   parameter int unsigned MAX_LEN = uss_pkg::MAX_LEN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  uss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output uss_pkg::rsp_type rsp_data
);

   localparam int unsigned PW = $clog2(MAX_LEN + 1);
   localparam int unsigned CW = (PW > 12) ? PW : 12;

   logic [PW-1:0]       pos_ff, pos_in;
   uss_pkg::phase_type  phase_ff, phase_in;
   logic [5:0]          idc_ff, idc_in;
   logic                failed_ff, failed_in;
   logic                prev_q_ff, prev_q_in;
   logic                prev_hyph_ff, prev_hyph_in;
   logic                rf_ff, rf_in;
   logic [PW-1:0]       ra_ff, ra_in;
   logic                qf_ff, qf_in;
   logic [PW-1:0]       qa_ff, qa_in;
   logic                ff_ff, ff_in;
   logic [PW-1:0]       fa_ff, fa_in;

   logic                rsp_valid_ff;
   uss_pkg::rsp_type    rsp_ff, rsp_in;

   logic                accept;
   logic                alive;
   logic [7:0]          ch;
   logic [PW-1:0]       off;
   logic [CW-1:0]       nl, nend, ra_w, qa_w, fa_w, r_end, q_end;

   assign ch        = req_data.text_byte;
   assign req_ready = !rsp_valid_ff || rsp_ready || !req_data.last_byte;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign alive = !failed_ff && (pos_ff < PW'(MAX_LEN)) && (ch != uss_pkg::CHAR_NUL);
   assign off   = pos_ff - PW'(uss_pkg::NSS_BASE) - PW'(idc_ff);

   // next scan state for the byte on the request port
   always_comb begin
      failed_in    = !alive;
      phase_in     = phase_ff;
      idc_in       = idc_ff;
      prev_q_in    = prev_q_ff;
      prev_hyph_in = prev_hyph_ff;
      rf_in        = rf_ff;
      ra_in        = ra_ff;
      qf_in        = qf_ff;
      qa_in        = qa_ff;
      ff_in        = ff_ff;
      fa_in        = fa_ff;
      if (alive) begin
         case (phase_ff)
            uss_pkg::PHASE_PREFIX: begin
               if (ch != uss_pkg::prefix_char(pos_ff[1:0])) begin
                  failed_in = 1'b1;
               end else if (pos_ff == PW'(uss_pkg::PREFIX_LEN - 1)) begin
                  phase_in = uss_pkg::PHASE_NID;
               end
            end
            uss_pkg::PHASE_NID: begin
               if (ch == uss_pkg::CHAR_COLON) begin
                  if (idc_ff < 6'(uss_pkg::NID_MIN) || idc_ff > 6'(uss_pkg::NID_MAX) ||
                      prev_hyph_ff) begin
                     failed_in = 1'b1;
                  end
                  phase_in  = uss_pkg::PHASE_NSS;
                  prev_q_in = 1'b0;
               end else begin
                  if (!uss_pkg::id_char_ok(ch) ||
                      (idc_ff == 6'd0 && ch == uss_pkg::CHAR_HYPHEN)) begin
                     failed_in = 1'b1;
                  end
                  idc_in = idc_ff + 6'd1;
                  if (idc_ff >= 6'(uss_pkg::NID_MAX)) begin
                     failed_in = 1'b1;
                  end
                  prev_hyph_in = (ch == uss_pkg::CHAR_HYPHEN);
               end
            end
            default: begin
               if (ch == uss_pkg::CHAR_HASH && !ff_ff) begin
                  ff_in = 1'b1;
                  fa_in = off;
               end
               if (prev_q_ff && ch == uss_pkg::CHAR_PLUS && !rf_ff) begin
                  rf_in = 1'b1;
                  ra_in = off - PW'(1);
               end
               if (prev_q_ff && ch == uss_pkg::CHAR_EQUAL && !qf_ff) begin
                  qf_in = 1'b1;
                  qa_in = off - PW'(1);
               end
               prev_q_in = (ch == uss_pkg::CHAR_QUESTION);
            end
         endcase
      end
      pos_in = failed_in ? pos_ff : pos_ff + PW'(1);
   end

   // result from the state after this byte
   always_comb begin
      nl   = CW'(pos_in) - CW'(uss_pkg::NSS_BASE) - CW'(idc_in);
      ra_w = CW'(ra_in);
      qa_w = CW'(qa_in);
      fa_w = CW'(fa_in);
      nend = nl;
      if (rf_in && ra_w < nend) begin
         nend = ra_w;
      end
      if (qf_in && qa_w < nend) begin
         nend = qa_w;
      end
      if (ff_in && fa_w < nend) begin
         nend = fa_w;
      end
      if (qf_in && qa_w > ra_w) begin
         r_end = qa_w;
      end else if (ff_in && fa_w > ra_w) begin
         r_end = fa_w;
      end else begin
         r_end = nl;
      end
      q_end = (ff_in && fa_w > qa_w) ? fa_w : nl;

      rsp_in = '0;
      if (!failed_in && phase_in == uss_pkg::PHASE_NSS && nl != '0 && nend != '0) begin
         rsp_in.valid_res = 1'b1;
         rsp_in.nid_len   = idc_in;
         rsp_in.nss_len   = nend[11:0];
         if (rf_in) begin
            rsp_in.has_r   = 1'b1;
            rsp_in.r_start = 12'(ra_w + CW'(2));
            rsp_in.r_len   = 12'(r_end - (ra_w + CW'(2)));
         end
         if (qf_in) begin
            rsp_in.has_q   = 1'b1;
            rsp_in.q_start = 12'(qa_w + CW'(2));
            rsp_in.q_len   = 12'(q_end - (qa_w + CW'(2)));
         end
         if (ff_in) begin
            rsp_in.has_f   = 1'b1;
            rsp_in.f_start = 12'(fa_w + CW'(1));
            rsp_in.f_len   = 12'(nl - (fa_w + CW'(1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_byte)) begin
         pos_ff       <= '0;
         phase_ff     <= uss_pkg::PHASE_PREFIX;
         idc_ff       <= '0;
         failed_ff    <= 1'b0;
         prev_q_ff    <= 1'b0;
         prev_hyph_ff <= 1'b0;
         rf_ff        <= 1'b0;
         ra_ff        <= '0;
         qf_ff        <= 1'b0;
         qa_ff        <= '0;
         ff_ff        <= 1'b0;
         fa_ff        <= '0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         idc_ff       <= idc_in;
         failed_ff    <= failed_in;
         prev_q_ff    <= prev_q_in;
         prev_hyph_ff <= prev_hyph_in;
         rf_ff        <= rf_in;
         ra_ff        <= ra_in;
         qf_ff        <= qf_in;
         qa_ff        <= qa_in;
         ff_ff        <= ff_in;
         fa_ff        <= fa_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_data.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   // position counter is bounded by the length limit
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_LEN))
      else $error("position beyond length limit");

   // a name ends with the scan state back at its start
   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> pos_ff == '0 && !failed_ff &&
      phase_ff == uss_pkg::PHASE_PREFIX)
      else $error("scan state not cleared after last byte");

   // once failed, the position holds until the name ends
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      failed_ff && !(accept && req_data.last_byte) |=> pos_ff == $past(pos_ff))
      else $error("position moved after failure");

   // a good name always carries a legal id length and a nonempty specific string
   a_nid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.valid_res |->
      rsp_ff.nid_len >= 6'(uss_pkg::NID_MIN) && rsp_ff.nid_len <= 6'(uss_pkg::NID_MAX) &&
      rsp_ff.nss_len != 12'd0)
      else $error("valid response with bad lengths");

   // a rejected name reports no parts
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.valid_res |->
      rsp_ff.nid_len == 6'd0 && rsp_ff.nss_len == 12'd0 &&
      !rsp_ff.has_r && !rsp_ff.has_q && !rsp_ff.has_f)
      else $error("invalid response carries parts");

endmodule

>>> tb/urn_syntax_splitter_core_test.sv
`timescale 1ns / 1ps

module urn_syntax_splitter_core_test;

   localparam int unsigned NAME_LIMIT  = uss_pkg::MAX_LEN_DEFAULT;
   localparam int unsigned LONG_NAME   = 160;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned DRAIN_WAIT  = 4;

   // predicts the split of each name and holds the results still owed by the block
   class urn_split_board;
      uss_pkg::rsp_type   split_q[$];
      int unsigned        mismatches;
      int unsigned        position;
      int unsigned        id_count;
      uss_pkg::phase_type phase;
      bit                 failed;
      bit                 after_question;
      bit                 res_seen;
      bit                 qry_seen;
      bit                 frag_seen;
      int unsigned        res_off;
      int unsigned        qry_off;
      int unsigned        frag_off;
      logic [7:0]         last_id_char;

      function new();
         mismatches = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         position       = 0;
         id_count       = 0;
         phase          = uss_pkg::PHASE_PREFIX;
         failed         = 1'b0;
         after_question = 1'b0;
         res_seen       = 1'b0;
         qry_seen       = 1'b0;
         frag_seen      = 1'b0;
         res_off        = 0;
         qry_off        = 0;
         frag_off       = 0;
         last_id_char   = 8'h00;
      endfunction

      // digits, letters or hyphen
      function bit is_name_char(logic [7:0] ch);
         return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7a) ||
                (ch >= 8'h41 && ch <= 8'h5a) || ch == uss_pkg::CHAR_HYPHEN;
      endfunction

      function void scan_byte(logic [7:0] ch);
         int unsigned off;
         string       head;
         head = "urn:";
         if (position >= NAME_LIMIT || ch == uss_pkg::CHAR_NUL)
            failed = 1'b1;
         if (failed)
            return;
         case (phase)
            uss_pkg::PHASE_PREFIX: begin
               if (ch != head[position & 3])
                  failed = 1'b1;
               else if (position == uss_pkg::PREFIX_LEN - 1)
                  phase = uss_pkg::PHASE_NID;
            end
            uss_pkg::PHASE_NID: begin
               if (ch == uss_pkg::CHAR_COLON) begin
                  if (id_count < uss_pkg::NID_MIN || id_count > uss_pkg::NID_MAX ||
                      last_id_char == uss_pkg::CHAR_HYPHEN)
                     failed = 1'b1;
                  phase          = uss_pkg::PHASE_NSS;
                  after_question = 1'b0;
               end else begin
                  if (!is_name_char(ch) || (id_count == 0 && ch == uss_pkg::CHAR_HYPHEN))
                     failed = 1'b1;
                  id_count++;
                  if (id_count > uss_pkg::NID_MAX)
                     failed = 1'b1;
                  last_id_char = ch;
               end
            end
            default: begin
               off = position - (uss_pkg::NSS_BASE + id_count);
               if (ch == uss_pkg::CHAR_HASH && !frag_seen) begin
                  frag_seen = 1'b1;
                  frag_off  = off;
               end
               // markers are recorded at the question mark
               if (after_question && ch == uss_pkg::CHAR_PLUS && !res_seen) begin
                  res_seen = 1'b1;
                  res_off  = off - 1;
               end
               if (after_question && ch == uss_pkg::CHAR_EQUAL && !qry_seen) begin
                  qry_seen = 1'b1;
                  qry_off  = off - 1;
               end
               after_question = (ch == uss_pkg::CHAR_QUESTION);
            end
         endcase
      endfunction

      function void note_request(uss_pkg::req_type item);
         uss_pkg::rsp_type want;
         int unsigned      nl;
         int unsigned      nend;
         int unsigned      e;
         scan_byte(item.text_byte);
         if (!failed)
            position++;
         if (!item.last_byte)
            return;
         want = '0;
         if (!failed && phase == uss_pkg::PHASE_NSS) begin
            nl   = position - (uss_pkg::NSS_BASE + id_count);
            nend = nl;
            if (res_seen && res_off < nend)
               nend = res_off;
            if (qry_seen && qry_off < nend)
               nend = qry_off;
            if (frag_seen && frag_off < nend)
               nend = frag_off;
            if (nl != 0 && nend != 0) begin
               want.valid_res = 1'b1;
               want.nid_len   = id_count[5:0];
               want.nss_len   = nend[11:0];
               if (res_seen) begin
                  e = (qry_seen && qry_off > res_off) ? qry_off :
                      (frag_seen && frag_off > res_off) ? frag_off : nl;
                  want.has_r   = 1'b1;
                  want.r_start = 12'(res_off + 2);
                  want.r_len   = 12'(e - (res_off + 2));
               end
               if (qry_seen) begin
                  e = (frag_seen && frag_off > qry_off) ? frag_off : nl;
                  want.has_q   = 1'b1;
                  want.q_start = 12'(qry_off + 2);
                  want.q_len   = 12'(e - (qry_off + 2));
               end
               if (frag_seen) begin
                  want.has_f   = 1'b1;
                  want.f_start = 12'(frag_off + 1);
                  want.f_len   = 12'(nl - (frag_off + 1));
               end
            end
         end
         split_q.push_back(want);
         clear_scan();
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(string field, logic [11:0] got, logic [11:0] want);
         if (got !== want)
            report($sformatf("%s got %0d expected %0d", field, got, want));
      endtask

      task check_response(uss_pkg::rsp_type got);
         uss_pkg::rsp_type want;
         if (split_q.size() == 0) begin
            report("response with no name pending");
            return;
         end
         want = split_q.pop_front();
         compare_field("valid_res", 12'(got.valid_res), 12'(want.valid_res));
         compare_field("nid_len", 12'(got.nid_len), 12'(want.nid_len));
         compare_field("nss_len", got.nss_len, want.nss_len);
         compare_field("has_r", 12'(got.has_r), 12'(want.has_r));
         compare_field("r_start", got.r_start, want.r_start);
         compare_field("r_len", got.r_len, want.r_len);
         compare_field("has_q", 12'(got.has_q), 12'(want.has_q));
         compare_field("q_start", got.q_start, want.q_start);
         compare_field("q_len", got.q_len, want.q_len);
         compare_field("has_f", 12'(got.has_f), 12'(want.has_f));
         compare_field("f_start", got.f_start, want.f_start);
         compare_field("f_len", got.f_len, want.f_len);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   uss_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   uss_pkg::rsp_type rsp_data;

   urn_split_board board;
   logic [7:0]     name_bytes[$];
   int unsigned    byte_count;
   int unsigned    name_count;
   int unsigned    stall_cycles;
   bit             steady;
   string          pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";

   urn_syntax_splitter_core #(
      .MAX_LEN(NAME_LIMIT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_data);
      rsp_ready <= steady || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL urn_syntax_splitter_core");
         $finish;
      end
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++)
         name_bytes.push_back(s[i]);
   endtask

   task automatic send_name();
      uss_pkg::req_type item;
      foreach (name_bytes[i]) begin
         while (!steady && $urandom_range(99) < 10) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         item.text_byte = name_bytes[i];
         item.last_byte = (i == name_bytes.size() - 1);
         req_valid <= 1'b1;
         req_data  <= item;
         do @(posedge clock); while (!req_ready);
         board.note_request(item);
         byte_count++;
      end
      name_count++;
   endtask

   task automatic send_text(string s);
      name_bytes.delete();
      add_text(s);
      send_name();
   endtask

   task automatic send_nid_name(int unsigned nid_n);
      name_bytes.delete();
      add_text("urn:");
      repeat (nid_n) name_bytes.push_back(pool[$urandom_range(pool.len() - 2)]);
      add_text(":z");
      send_name();
   endtask

   // markers near both ends of a long specific string
   task automatic send_long_name(int unsigned total);
      name_bytes.delete();
      add_text("urn:ab:x?+");
      while (name_bytes.size() < total - 6)
         name_bytes.push_back(pool[$urandom_range(pool.len() - 1)]);
      add_text("?=q#ff");
      send_name();
   endtask

   task automatic build_random_name();
      int unsigned kind;
      int unsigned nid_n;
      int unsigned nss_n;
      int unsigned pick;
      name_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(20, 1)) name_bytes.push_back(8'($urandom_range(255, 1)));
         return;
      end
      add_text("urn:");
      if (kind < 12)
         name_bytes[$urandom_range(3)] = 8'($urandom_range(255, 1));
      nid_n = ($urandom_range(7) == 0) ? $urandom_range(35) : $urandom_range(8, 2);
      repeat (nid_n) name_bytes.push_back(pool[$urandom_range(pool.len() - 1)]);
      // hyphen at either edge of the id, or a stray byte in it
      if (nid_n > 0 && kind >= 12 && kind < 15)
         name_bytes[4] = uss_pkg::CHAR_HYPHEN;
      if (nid_n > 0 && kind >= 15 && kind < 18)
         name_bytes[name_bytes.size() - 1] = uss_pkg::CHAR_HYPHEN;
      if (nid_n > 0 && kind >= 18 && kind < 21)
         name_bytes[name_bytes.size() - 1] = 8'($urandom_range(255, 1));
      if (kind == 21)
         return;
      name_bytes.push_back(uss_pkg::CHAR_COLON);
      nss_n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(14, 1);
      repeat (nss_n) begin
         pick = $urandom_range(99);
         if (pick < 8)
            add_text("?+");
         else if (pick < 15)
            add_text("?=");
         else if (pick < 21)
            name_bytes.push_back(uss_pkg::CHAR_HASH);
         else if (pick < 27)
            name_bytes.push_back(uss_pkg::CHAR_QUESTION);
         else if (pick < 28)
            name_bytes.push_back(uss_pkg::CHAR_NUL);
         else if (pick < 34)
            name_bytes.push_back(8'($urandom_range(255, 1)));
         else
            name_bytes.push_back(pool[$urandom_range(pool.len() - 1)]);
      end
   endtask

   initial begin
      int unsigned byte_base;
      int unsigned name_base;
      board        = new();
      byte_count   = 0;
      name_count   = 0;
      steady       = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_text("urn:ab:c");
      send_text("urn:isbn:123?+res?=qq#frag");
      send_text("urn:ab:c?=q?+r#f");
      send_text("urn:ab:c#f?+r?=q");
      send_text("urn:ab:c??+x");
      send_text("urn:ab:c?+");
      send_text("urn:x:y");
      send_nid_name(uss_pkg::NID_MAX);
      send_nid_name(uss_pkg::NID_MAX + 1);
      send_text("urn:-ab:c");
      send_text("urn:ab-:c");
      send_text("urn:a_b:c");
      send_text("URN:ab:c");
      send_text("urn:ab:");
      send_text("urn:ab:?+x");
      send_text("urn:ab:?=x");
      send_text("urn:ab:#f");
      send_text("urn");
      send_text("urn:abc");
      name_bytes.delete();
      name_bytes.push_back(8'hff);
      send_name();
      name_bytes.delete();
      add_text("urn:ab:c");
      name_bytes.push_back(uss_pkg::CHAR_NUL);
      add_text("d");
      send_name();
      send_long_name(LONG_NAME);

      byte_base = byte_count;
      name_base = name_count;
      while (byte_count - byte_base < 300 || name_count - name_base < 20) begin
         steady = (name_count - name_base >= 8 && name_count - name_base < 16);
         if (name_count - name_base == 4) begin
            // hold off until the block has answered everything
            req_valid <= 1'b0;
            do @(posedge clock); while (board.split_q.size() != 0);
         end
         build_random_name();
         send_name();
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      do @(posedge clock); while (board.split_q.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.mismatches == 0 && board.split_q.size() == 0)
         $display("PASS urn_syntax_splitter_core");
      else
         $display("FAIL urn_syntax_splitter_core");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/uss_pkg.sv
rtl/core/urn_syntax_splitter_core.sv
tb/urn_syntax_splitter_core_test.sv
